### hw/rtl/shrp_pkg.sv
// ----------------------------------------------------------------------------
// Sensor-hub report parser package
// Shared constants, codes and types for the report parser and its classifier.
// ----------------------------------------------------------------------------
package shrp_pkg;

    localparam int MAX_PACKET_BYTES = 256;

    localparam int BYTE_W    = 8;
    localparam int POS_W     = 15;
    localparam int KIND_W    = 3;
    localparam int RIDX_W    = 4;
    localparam int AXIS_W    = 16;
    localparam int FRAC_W    = 4;
    localparam int ACC_W     = 2;
    localparam int CAUSE_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_DATA  = 8;
    localparam int DIDX_W    = 3;
    localparam int M_DATA_W  = 80;

    localparam logic [POS_W-1:0] MAX_PACKET_LEN = POS_W'(MAX_PACKET_BYTES);
    localparam logic [POS_W-1:0] LEN_ALL_ONES   = '1;
    localparam logic [POS_W-1:0] MIN_REPORT_LEN = POS_W'(4);

    localparam logic [KIND_W-1:0] KIND_ROT    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_GAME   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ACC    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_GYRO   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REJECT = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SKIP   = 3'd5;

    localparam logic [CAUSE_W-1:0] CAUSE_NONE    = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_LENGTH  = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_CHANNEL = 2'd2;

    localparam logic [RIDX_W-1:0] LEN_TIMESTAMP = 4'd5;
    localparam logic [RIDX_W-1:0] LEN_ROT       = 4'd14;
    localparam logic [RIDX_W-1:0] LEN_GAME      = 4'd12;
    localparam logic [RIDX_W-1:0] LEN_AXIS3     = 4'd10;

    localparam logic [RIDX_W-1:0] RIDX_ID     = 4'd0;
    localparam logic [RIDX_W-1:0] RIDX_STATUS = 4'd2;
    localparam logic [RIDX_W-1:0] RIDX_DATA   = 4'd4;
    localparam logic [RIDX_W-1:0] RIDX_END    = 4'd12;

    localparam logic [FRAC_W-1:0] FRAC_QUAT  = 4'd14;
    localparam logic [FRAC_W-1:0] FRAC_ACCEL = 4'd8;
    localparam logic [FRAC_W-1:0] FRAC_GYRO  = 4'd9;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_ROT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_GAME     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_ACCEL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_LINEAR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_GRAVITY  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_GYRO     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_TIMESTMP = 3'd7;

    typedef struct packed {
        logic [BYTE_W-1:0] report_channel;
        logic [BYTE_W-1:0] id_rotation;
        logic [BYTE_W-1:0] id_game_rotation;
        logic [BYTE_W-1:0] id_accel;
        logic [BYTE_W-1:0] id_linear_accel;
        logic [BYTE_W-1:0] id_gravity;
        logic [BYTE_W-1:0] id_gyro;
        logic [BYTE_W-1:0] id_timestamp;
    } cfg_t;

    typedef struct packed {
        logic              known;
        logic [KIND_W-1:0] kind;
        logic [RIDX_W-1:0] len;
    } class_t;

endpackage

### hw/rtl/shrp_classify.sv
// ----------------------------------------------------------------------------
// Report ID classifier
// Maps a record ID byte to its record kind and length using the ID registers.
// ----------------------------------------------------------------------------
module shrp_classify (
    input  shrp_pkg::cfg_t              cfg,
    input  logic [shrp_pkg::BYTE_W-1:0] id,
    output shrp_pkg::class_t            cls
);
    import shrp_pkg::*;

    always_comb begin
        cls = '0;
        priority if (id == cfg.id_timestamp) begin
            cls = '{known: 1'b1, kind: KIND_SKIP, len: LEN_TIMESTAMP};
        end else if (id == cfg.id_rotation) begin
            cls = '{known: 1'b1, kind: KIND_ROT, len: LEN_ROT};
        end else if (id == cfg.id_game_rotation) begin
            cls = '{known: 1'b1, kind: KIND_GAME, len: LEN_GAME};
        end else if (id == cfg.id_accel || id == cfg.id_linear_accel
                     || id == cfg.id_gravity) begin
            cls = '{known: 1'b1, kind: KIND_ACC, len: LEN_AXIS3};
        end else if (id == cfg.id_gyro) begin
            cls = '{known: 1'b1, kind: KIND_GYRO, len: LEN_AXIS3};
        end else begin
            cls = '0;
        end
    end

endmodule

### hw/rtl/sensor_hub_report_parser_core.sv
// ----------------------------------------------------------------------------
// Sensor-hub report parser core
// Parses transport packet bytes into sensor input report words.
// A byte is held in the input register and its result word in the output register.
// Throughput: one byte per cycle; s_tready drops only while both registers are
// full and the held result word is not taken.
// Reset (aresetn low, synchronous) leaves the parser outside any packet.
// ----------------------------------------------------------------------------
module sensor_hub_report_parser_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [shrp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [shrp_pkg::BYTE_W-1:0]           cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // Fields: data_byte[7:0].
    input  logic [shrp_pkg::BYTE_W-1:0]           s_tdata,
    // Fields: packet_start[0].
    input  logic [0:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // Fields: record_id[7:0], axis_x[23:8], axis_y[39:24], axis_z[55:40],
    // axis_w[71:56], frac_bits[75:72], accuracy[77:76], reject_cause[79:78].
    output logic [shrp_pkg::M_DATA_W-1:0]         m_tdata,
    // Fields: kind[2:0].
    output logic [shrp_pkg::KIND_W-1:0]           m_tuser
);
    import shrp_pkg::*;

    cfg_t cfg_reg;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_data_reg;
    logic              in_start_reg;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  plen_reg, plen_next;
    logic              accepting_reg, accepting_next;
    logic [RIDX_W-1:0] ridx_reg, ridx_next;
    logic [RIDX_W-1:0] rlen_reg, rlen_next;
    logic [KIND_W-1:0] rkind_reg, rkind_next;
    logic [BYTE_W-1:0] rident_reg, rident_next;
    logic [ACC_W-1:0]  status_reg, status_next;
    logic [BYTE_W-1:0] data_reg [NUM_DATA];
    logic [BYTE_W-1:0] data_cur [NUM_DATA];
    logic              data_we;
    logic [DIDX_W-1:0] data_idx;

    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic [KIND_W-1:0]   m_tuser_reg;

    logic                res_valid;
    logic [M_DATA_W-1:0] res_data;
    logic [KIND_W-1:0]   res_kind;

    logic              out_ready;
    logic              proc_go;
    logic              acc_e;
    logic [POS_W-1:0]  pos_e;
    logic [RIDX_W-1:0] ridx_e;
    logic [POS_W-1:0]  len_hdr;
    logic [POS_W-1:0]  pos_inc;
    logic [RIDX_W:0]   idx_inc;
    logic [KIND_W-1:0] kind_use;
    logic [RIDX_W-1:0] len_use;
    logic              advance;
    logic [AXIS_W-1:0] ax_x, ax_y, ax_z, ax_w;
    logic [FRAC_W-1:0] frac;
    logic [ACC_W-1:0]  accu;
    class_t            cls;

    shrp_classify u_classify (
        .cfg (cfg_reg),
        .id  (in_data_reg),
        .cls (cls)
    );

    assign out_ready = !m_tvalid_reg || m_tready;
    assign proc_go   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;

    assign acc_e   = in_start_reg ? 1'b1 : accepting_reg;
    assign pos_e   = in_start_reg ? '0 : pos_reg;
    assign ridx_e  = in_start_reg ? '0 : ridx_reg;
    assign len_hdr = {in_data_reg[6:0], plen_reg[BYTE_W-1:0]};
    assign pos_inc = pos_e + POS_W'(1);
    assign idx_inc = {1'b0, ridx_e} + (RIDX_W+1)'(1);
    assign data_idx = DIDX_W'(ridx_e - RIDX_DATA);

    always_comb begin
        for (int i = 0; i < NUM_DATA; i++) begin
            data_cur[i] = data_reg[i];
        end
        if (data_we) begin
            data_cur[data_idx] = in_data_reg;
        end
    end

    always_comb begin
        ax_x = {data_cur[1], data_cur[0]};
        ax_y = {data_cur[3], data_cur[2]};
        ax_z = {data_cur[5], data_cur[4]};
        ax_w = {data_cur[7], data_cur[6]};
        accu = '0;
        frac = FRAC_GYRO;
        if (kind_use == KIND_ROT || kind_use == KIND_GAME) begin
            frac = FRAC_QUAT;
            accu = status_next;
        end else begin
            ax_w = '0;
            frac = (kind_use == KIND_ACC) ? FRAC_ACCEL : FRAC_GYRO;
        end
    end

    always_comb begin
        pos_next       = pos_reg;
        plen_next      = plen_reg;
        accepting_next = accepting_reg;
        ridx_next      = ridx_reg;
        rlen_next      = rlen_reg;
        rkind_next     = rkind_reg;
        rident_next    = rident_reg;
        status_next    = status_reg;
        data_we        = 1'b0;
        res_valid      = 1'b0;
        res_kind       = KIND_REJECT;
        res_data       = '0;
        advance        = 1'b0;
        kind_use       = (ridx_e == RIDX_ID) ? cls.kind : rkind_reg;
        len_use        = (ridx_e == RIDX_ID) ? cls.len : (in_start_reg ? '0 : rlen_reg);

        if (proc_go && in_start_reg) begin
            accepting_next = 1'b1;
            pos_next       = '0;
            ridx_next      = '0;
            rlen_next      = '0;
        end

        if (proc_go && acc_e) begin
            advance = 1'b1;
            priority if (pos_e == POS_W'(0)) begin
                plen_next = {{(POS_W-BYTE_W){1'b0}}, in_data_reg};
            end else if (pos_e == POS_W'(1)) begin
                if (len_hdr == '0 || len_hdr == LEN_ALL_ONES) begin
                    res_valid                         = 1'b1;
                    res_data[M_DATA_W-1 -: CAUSE_W]   = CAUSE_LENGTH;
                    accepting_next                    = 1'b0;
                    advance                           = 1'b0;
                end else begin
                    plen_next = (len_hdr > MAX_PACKET_LEN) ? MAX_PACKET_LEN : len_hdr;
                end
            end else if (pos_e == POS_W'(2)) begin
                if (in_data_reg != cfg_reg.report_channel || plen_reg <= MIN_REPORT_LEN) begin
                    res_valid                         = 1'b1;
                    res_data[M_DATA_W-1 -: CAUSE_W]   = CAUSE_CHANNEL;
                    accepting_next                    = 1'b0;
                    advance                           = 1'b0;
                end
            end else if (pos_e >= POS_W'(4)) begin
                if (ridx_e == RIDX_ID && !cls.known) begin
                    accepting_next = 1'b0;
                    advance        = 1'b0;
                end else begin
                    if (ridx_e == RIDX_ID) begin
                        rkind_next  = cls.kind;
                        rlen_next   = cls.len;
                        rident_next = in_data_reg;
                    end
                    if (ridx_e == RIDX_STATUS) begin
                        status_next = in_data_reg[ACC_W-1:0];
                    end
                    if (ridx_e >= RIDX_DATA && ridx_e < RIDX_END) begin
                        data_we = 1'b1;
                    end
                    if (idx_inc >= {1'b0, len_use}) begin
                        ridx_next = '0;
                        if (kind_use != KIND_SKIP) begin
                            res_valid = 1'b1;
                            res_kind  = kind_use;
                            res_data  = {CAUSE_NONE, accu, frac, ax_w, ax_z, ax_y, ax_x,
                                         rident_next};
                        end
                    end else begin
                        ridx_next = idx_inc[RIDX_W-1:0];
                    end
                end
            end else begin
                plen_next = plen_reg;
            end

            if (advance) begin
                pos_next = pos_inc;
                if (pos_e >= POS_W'(3) && pos_inc >= plen_next) begin
                    accepting_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.report_channel   <= 8'd3;
            cfg_reg.id_rotation      <= 8'd5;
            cfg_reg.id_game_rotation <= 8'd8;
            cfg_reg.id_accel         <= 8'd1;
            cfg_reg.id_linear_accel  <= 8'd4;
            cfg_reg.id_gravity       <= 8'd6;
            cfg_reg.id_gyro          <= 8'd2;
            cfg_reg.id_timestamp     <= 8'd251;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_CHANNEL:     cfg_reg.report_channel   <= cfg_wdata;
                CFG_ID_ROT:      cfg_reg.id_rotation      <= cfg_wdata;
                CFG_ID_GAME:     cfg_reg.id_game_rotation <= cfg_wdata;
                CFG_ID_ACCEL:    cfg_reg.id_accel         <= cfg_wdata;
                CFG_ID_LINEAR:   cfg_reg.id_linear_accel  <= cfg_wdata;
                CFG_ID_GRAVITY:  cfg_reg.id_gravity       <= cfg_wdata;
                CFG_ID_GYRO:     cfg_reg.id_gyro          <= cfg_wdata;
                CFG_ID_TIMESTMP: cfg_reg.id_timestamp     <= cfg_wdata;
                default:         cfg_reg.id_timestamp     <= cfg_reg.id_timestamp;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg  <= s_tdata;
            in_start_reg <= s_tuser[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            plen_reg      <= '0;
            accepting_reg <= 1'b0;
            ridx_reg      <= '0;
            rlen_reg      <= '0;
            rkind_reg     <= '0;
            rident_reg    <= '0;
            status_reg    <= '0;
        end else begin
            pos_reg       <= pos_next;
            plen_reg      <= plen_next;
            accepting_reg <= accepting_next;
            ridx_reg      <= ridx_next;
            rlen_reg      <= rlen_next;
            rkind_reg     <= rkind_next;
            rident_reg    <= rident_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (data_we) begin
            data_reg[data_idx] <= in_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (proc_go) begin
            m_tvalid_reg <= res_valid;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_go && res_valid) begin
            m_tdata_reg <= res_data;
            m_tuser_reg <= res_kind;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### bench/sensor_hub_report_parser_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sensor-hub report parser core testbench
// Drives transport packets into the parser one byte word at a time and checks
// every result word against a cycle-free model of the packet and record
// decoding. Directed packets cover the header rejections, every record kind,
// cut-off records, unknown IDs, length clipping and ID priority; random
// packets then run under several register settings, with random idling on
// both sides in all but the last setting.
// ----------------------------------------------------------------------------
module sensor_hub_report_parser_core_tb;
    import shrp_pkg::*;

    localparam int PERIOD        = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int NUM_REGS      = $bits(cfg_t) / BYTE_W;

    typedef logic [BYTE_W-1:0] byte_q_t[$];

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [CAUSE_W-1:0]        cause;
        logic [ACC_W-1:0]          accuracy;
        logic [FRAC_W-1:0]         frac_bits;
        logic signed [AXIS_W-1:0]  axis_w;
        logic signed [AXIS_W-1:0]  axis_z;
        logic signed [AXIS_W-1:0]  axis_y;
        logic signed [AXIS_W-1:0]  axis_x;
        logic [BYTE_W-1:0]         record_id;
    } hub_report_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [BYTE_W-1:0]      cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata   = '0;
    logic [0:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_DATA_W-1:0]    m_tdata;
    logic [KIND_W-1:0]      m_tuser;

    sensor_hub_report_parser_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Model state of the parser.
    cfg_t                hub_cfg;
    logic [POS_W-1:0]    pkt_pos    = '0;
    logic [POS_W-1:0]    pkt_len    = '0;
    logic                in_packet  = 1'b0;
    logic [RIDX_W-1:0]   rec_idx    = '0;
    logic [RIDX_W-1:0]   rec_len    = '0;
    logic [KIND_W-1:0]   rec_kind   = '0;
    logic [BYTE_W-1:0]   rec_ident  = '0;
    logic [ACC_W-1:0]    rec_status = '0;
    logic [BYTE_W-1:0]   rec_bytes[NUM_DATA];

    hub_report_t expected_reports[$];
    int          mismatches    = 0;
    int          cycle_count   = 0;
    int          words_sent    = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    always #(PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic class_t classify_id(input logic [BYTE_W-1:0] id);
        class_t c;
        c.known = 1'b1;
        if (id == hub_cfg.id_timestamp) begin
            c.kind = KIND_SKIP;
            c.len  = LEN_TIMESTAMP;
        end else if (id == hub_cfg.id_rotation) begin
            c.kind = KIND_ROT;
            c.len  = LEN_ROT;
        end else if (id == hub_cfg.id_game_rotation) begin
            c.kind = KIND_GAME;
            c.len  = LEN_GAME;
        end else if (id == hub_cfg.id_accel || id == hub_cfg.id_linear_accel ||
                     id == hub_cfg.id_gravity) begin
            c.kind = KIND_ACC;
            c.len  = LEN_AXIS3;
        end else if (id == hub_cfg.id_gyro) begin
            c.kind = KIND_GYRO;
            c.len  = LEN_AXIS3;
        end else begin
            c.known = 1'b0;
            c.kind  = KIND_SKIP;
            c.len   = '0;
        end
        return c;
    endfunction

    task automatic push_reject(input logic [CAUSE_W-1:0] cause);
        hub_report_t r;
        r        = '0;
        r.kind   = KIND_REJECT;
        r.cause  = cause;
        in_packet = 1'b0;
        expected_reports.push_back(r);
    endtask

    task automatic decode_hub_byte(input logic [BYTE_W-1:0] data, input logic start);
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  full_len;
        logic [RIDX_W:0]   idx;
        logic [RIDX_W:0]   slot;
        class_t            c;
        hub_report_t       r;
        if (start) begin
            in_packet = 1'b1;
            pkt_pos   = '0;
            rec_idx   = '0;
            rec_len   = '0;
        end
        if (!in_packet) return;
        pos = pkt_pos;
        if (pos == 0) begin
            pkt_len = POS_W'(data);
        end else if (pos == 1) begin
            full_len = {data[6:0], pkt_len[7:0]};
            if (full_len == '0 || full_len == LEN_ALL_ONES) begin
                push_reject(CAUSE_LENGTH);
                return;
            end
            if (full_len > MAX_PACKET_LEN) full_len = MAX_PACKET_LEN;
            pkt_len = full_len;
        end else if (pos == 2) begin
            if (data != hub_cfg.report_channel || pkt_len <= MIN_REPORT_LEN) begin
                push_reject(CAUSE_CHANNEL);
                return;
            end
        end else if (pos >= 4) begin
            idx = {1'b0, rec_idx};
            if (idx == RIDX_ID) begin
                c = classify_id(data);
                if (!c.known) begin
                    in_packet = 1'b0;
                    return;
                end
                rec_kind  = c.kind;
                rec_len   = c.len;
                rec_ident = data;
            end else if (idx == RIDX_STATUS) begin
                rec_status = data[ACC_W-1:0];
            end else if (idx >= RIDX_DATA && idx < RIDX_END) begin
                slot = idx - RIDX_DATA;
                rec_bytes[slot[DIDX_W-1:0]] = data;
            end
            idx++;
            if (idx >= rec_len) begin
                if (rec_kind != KIND_SKIP) begin
                    r           = '0;
                    r.kind      = rec_kind;
                    r.record_id = rec_ident;
                    r.axis_x    = {rec_bytes[1], rec_bytes[0]};
                    r.axis_y    = {rec_bytes[3], rec_bytes[2]};
                    r.axis_z    = {rec_bytes[5], rec_bytes[4]};
                    r.cause     = CAUSE_NONE;
                    if (rec_kind == KIND_ROT || rec_kind == KIND_GAME) begin
                        r.axis_w    = {rec_bytes[7], rec_bytes[6]};
                        r.frac_bits = FRAC_QUAT;
                        r.accuracy  = rec_status;
                    end else begin
                        r.frac_bits = (rec_kind == KIND_ACC) ? FRAC_ACCEL : FRAC_GYRO;
                    end
                    expected_reports.push_back(r);
                end
                idx = '0;
            end
            rec_idx = idx[RIDX_W-1:0];
        end
        pkt_pos = pos + 1'b1;
        if (pos >= 3 && pkt_pos >= pkt_len) in_packet = 1'b0;
    endtask

    task automatic report_mismatch(input string what, input hub_report_t want,
                                   input hub_report_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s at %0t ns", what, $time);
            $display(
                "  expected: kind %0d id %0d x %0d y %0d z %0d w %0d frac %0d acc %0d cause %0d",
                want.kind, want.record_id, want.axis_x, want.axis_y, want.axis_z,
                want.axis_w, want.frac_bits, want.accuracy, want.cause);
            $display(
                "  actual:   kind %0d id %0d x %0d y %0d z %0d w %0d frac %0d acc %0d cause %0d",
                got.kind, got.record_id, got.axis_x, got.axis_y, got.axis_z,
                got.axis_w, got.frac_bits, got.accuracy, got.cause);
        end
    endtask

    always @(posedge aclk) begin
        hub_report_t want;
        hub_report_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) decode_hub_byte(s_tdata, s_tuser[0]);
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata};
                if (expected_reports.size() == 0) begin
                    report_mismatch("Unexpected result word", '0, got);
                end else begin
                    want = expected_reports.pop_front();
                    if (got.kind !== want.kind || got.record_id !== want.record_id ||
                        got.axis_x !== want.axis_x || got.axis_y !== want.axis_y ||
                        got.axis_z !== want.axis_z || got.axis_w !== want.axis_w ||
                        got.frac_bits !== want.frac_bits ||
                        got.accuracy !== want.accuracy || got.cause !== want.cause)
                        report_mismatch("Result word mismatch", want, got);
                end
            end
        end
    end

    task automatic send_word(input logic [BYTE_W-1:0] data, input logic start);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    task automatic send_bytes(input byte_q_t q, input int count);
        for (int i = 0; i < count && i < q.size(); i++) send_word(q[i], i == 0);
    endtask

    task automatic drain_results;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_config(input cfg_t c);
        logic [CFG_IDX_W-1:0] reg_idx;
        drain_results();
        for (int i = 0; i < NUM_REGS; i++) begin
            reg_idx = CFG_IDX_W'(i);
            cfg_wr_en <= 1'b1;
            cfg_index <= reg_idx;
            case (reg_idx)
                CFG_CHANNEL:     cfg_wdata <= c.report_channel;
                CFG_ID_ROT:      cfg_wdata <= c.id_rotation;
                CFG_ID_GAME:     cfg_wdata <= c.id_game_rotation;
                CFG_ID_ACCEL:    cfg_wdata <= c.id_accel;
                CFG_ID_LINEAR:   cfg_wdata <= c.id_linear_accel;
                CFG_ID_GRAVITY:  cfg_wdata <= c.id_gravity;
                CFG_ID_GYRO:     cfg_wdata <= c.id_gyro;
                CFG_ID_TIMESTMP: cfg_wdata <= c.id_timestamp;
                default:         cfg_wdata <= '0;
            endcase
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        hub_cfg = c;
        @(posedge aclk);
    endtask

    function automatic byte_q_t concat_bytes(input byte_q_t a, input byte_q_t b);
        foreach (b[i]) a.push_back(b[i]);
        return a;
    endfunction

    function automatic byte_q_t make_record(input logic [BYTE_W-1:0] id,
                                            input logic [BYTE_W-1:0] status,
                                            input logic [AXIS_W-1:0] x, input logic [AXIS_W-1:0] y,
                                            input logic [AXIS_W-1:0] z, input logic [AXIS_W-1:0] w);
        byte_q_t           q;
        class_t            c;
        logic [BYTE_W-1:0] full[14];
        c    = classify_id(id);
        full = '{id, 8'($urandom), status, 8'($urandom), x[7:0], x[15:8], y[7:0], y[15:8],
                 z[7:0], z[15:8], w[7:0], w[15:8], 8'($urandom), 8'($urandom)};
        if (!c.known) q.push_back(id);
        for (int i = 0; i < int'(c.len); i++) q.push_back(full[i]);
        return q;
    endfunction

    function automatic byte_q_t random_record(input logic [BYTE_W-1:0] id);
        return make_record(id, 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom));
    endfunction

    function automatic byte_q_t frame(input logic [15:0] len_field,
                                      input logic [BYTE_W-1:0] channel,
                                      input byte_q_t payload);
        byte_q_t q;
        q.push_back(len_field[7:0]);
        q.push_back(len_field[15:8]);
        q.push_back(channel);
        q.push_back(8'($urandom));
        return concat_bytes(q, payload);
    endfunction

    function automatic logic [15:0] exact_len(input byte_q_t payload);
        return {1'($urandom), 15'(4 + payload.size())};
    endfunction

    function automatic logic [BYTE_W-1:0] pick_id();
        case ($urandom_range(0, 6))
            0:       return hub_cfg.id_timestamp;
            1:       return hub_cfg.id_rotation;
            2:       return hub_cfg.id_game_rotation;
            3:       return hub_cfg.id_accel;
            4:       return hub_cfg.id_linear_accel;
            5:       return hub_cfg.id_gravity;
            default: return hub_cfg.id_gyro;
        endcase
    endfunction

    task automatic test_stray_words;
        send_word(8'h04, 1'b0);
        send_word(8'hFB, 1'b0);
    endtask

    task automatic test_bad_length;
        byte_q_t rec;
        rec = random_record(hub_cfg.id_accel);
        send_bytes(frame(16'h0000, hub_cfg.report_channel, rec), 4 + rec.size());
        send_bytes(frame(16'h7FFF, hub_cfg.report_channel, rec), 3);
        send_bytes(frame(16'hFFFF, hub_cfg.report_channel, rec), 2);
    endtask

    task automatic test_bad_channel;
        byte_q_t rec;
        rec = random_record(hub_cfg.id_gyro);
        send_bytes(frame(16'd14, hub_cfg.report_channel + 8'd1, rec), 6);
        send_bytes(frame(16'h8004, hub_cfg.report_channel, rec), 5);
        send_bytes(frame(16'd1, hub_cfg.report_channel, rec), 3);
    endtask

    task automatic test_all_records;
        byte_q_t p;
        p = random_record(hub_cfg.id_timestamp);
        p = concat_bytes(p, make_record(hub_cfg.id_rotation, 8'hFF, 16'h8000, 16'h7FFF,
                                        16'h0000, 16'hFFFF));
        p = concat_bytes(p, make_record(hub_cfg.id_game_rotation, 8'h02, 16'h0001, 16'hFFFE,
                                        16'h1234, 16'h8001));
        p = concat_bytes(p, make_record(hub_cfg.id_accel, 8'h03, 16'h7FFF, 16'h8000,
                                        16'hFFFF, 16'h5555));
        p = concat_bytes(p, random_record(hub_cfg.id_linear_accel));
        p = concat_bytes(p, random_record(hub_cfg.id_gravity));
        p = concat_bytes(p, make_record(hub_cfg.id_gyro, 8'h01, 16'hFFFF, 16'h0000,
                                        16'h8000, 16'hAAAA));
        send_bytes(frame(16'h8000 | 16'(4 + p.size()), hub_cfg.report_channel, p), 4 + p.size());
    endtask

    task automatic test_cut_records;
        byte_q_t rec;
        rec = random_record(hub_cfg.id_accel);
        send_bytes(frame(16'd11, hub_cfg.report_channel, rec), 4 + rec.size());
        rec = random_record(hub_cfg.id_rotation);
        send_bytes(frame(exact_len(rec), hub_cfg.report_channel, rec), 10);
        rec = random_record(hub_cfg.id_gyro);
        send_bytes(frame(exact_len(rec), hub_cfg.report_channel, rec), 4 + rec.size());
    endtask

    task automatic test_unknown_id;
        byte_q_t p;
        p = random_record(hub_cfg.id_gyro);
        p = concat_bytes(p, random_record(8'h77));
        p = concat_bytes(p, random_record(hub_cfg.id_accel));
        send_bytes(frame(exact_len(p), hub_cfg.report_channel, p), 4 + p.size());
    endtask

    task automatic test_length_clip;
        byte_q_t p;
        repeat (26) p = concat_bytes(p, random_record(hub_cfg.id_accel));
        send_bytes(frame(16'h0300, hub_cfg.report_channel, p), 4 + p.size());
    endtask

    task automatic test_id_priority;
        byte_q_t p;
        apply_config({8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
        p = concat_bytes(random_record(8'd0), random_record(8'd0));
        send_bytes(frame(exact_len(p), 8'd0, p), 4 + p.size());
        apply_config({8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255});
        p = concat_bytes(random_record(8'd0), random_record(8'd255));
        send_bytes(frame(exact_len(p), 8'd255, p), 4 + p.size());
        apply_config({8'd3, 8'd254, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255});
        p = concat_bytes(random_record(8'd0), random_record(8'd254));
        send_bytes(frame(exact_len(p), 8'd3, p), 4 + p.size());
        apply_config({8'd3, 8'd254, 8'd253, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255});
        p = random_record(8'd0);
        send_bytes(frame(exact_len(p), 8'd3, p), 4 + p.size());
    endtask

    task automatic test_random_traffic(input int word_goal, input int snd_pct, input int rcv_pct);
        int                goal;
        int                mode;
        byte_q_t           payload;
        byte_q_t           pkt;
        logic [15:0]       len_field;
        logic [BYTE_W-1:0] channel;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        goal = words_sent + word_goal;
        while (words_sent < goal) begin
            payload.delete();
            repeat ($urandom_range(1, 5)) payload = concat_bytes(payload, random_record(pick_id()));
            len_field = exact_len(payload);
            channel   = hub_cfg.report_channel;
            mode      = $urandom_range(0, 99);
            if (mode >= 65 && mode < 73) begin
                pkt = frame(len_field, channel, payload);
                send_bytes(pkt, $urandom_range(1, pkt.size() - 1));
            end else if (mode >= 99) begin
                repeat ($urandom_range(1, 8)) send_word(8'($urandom), $urandom_range(0, 9) == 0);
            end else begin
                if (mode >= 73 && mode < 78) begin
                    len_field[14:0] = 15'($urandom_range(5, 3 + payload.size()));
                end else if (mode >= 78 && mode < 84) begin
                    channel = channel ^ 8'($urandom_range(1, 255));
                end else if (mode >= 84 && mode < 91) begin
                    case ($urandom_range(0, 3))
                        0:       len_field[14:0] = '0;
                        1:       len_field[14:0] = LEN_ALL_ONES;
                        2:       len_field[14:0] = 15'($urandom_range(1, 4));
                        default: len_field[14:0] = 15'($urandom_range(257, 32766));
                    endcase
                end else if (mode >= 91) begin
                    payload = concat_bytes(payload, random_record(8'($urandom)));
                    payload = concat_bytes(payload, random_record(pick_id()));
                    len_field = exact_len(payload);
                end
                pkt = frame(len_field, channel, payload);
                send_bytes(pkt, pkt.size());
            end
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 4)) send_word(8'($urandom), 1'b0);
        end
    endtask

    initial begin
        hub_cfg = {8'd3, 8'd5, 8'd8, 8'd1, 8'd4, 8'd6, 8'd2, 8'd251};
        foreach (rec_bytes[i]) rec_bytes[i] = '0;
        send_idle_pct = 35;
        recv_idle_pct = 57;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_stray_words();
        test_bad_length();
        test_bad_channel();
        test_all_records();
        test_cut_records();
        test_unknown_id();
        test_length_clip();
        test_id_priority();

        apply_config({8'd3, 8'd5, 8'd8, 8'd1, 8'd4, 8'd6, 8'd2, 8'd251});
        test_random_traffic(200, 35, 57);
        apply_config(cfg_t'({$urandom, $urandom}));
        test_random_traffic(200, 57, 35);
        apply_config({8'd255, 8'd0, 8'd255, 8'd128, 8'd1, 8'd254, 8'd127, 8'd253});
        test_random_traffic(200, 0, 0);

        drain_results();
        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
